// ----- hw/rtl/wbd_pkg.sv -----
// wbd_pkg: shared constants, types and helpers for the 3x3 binary dilation block
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package wbd_pkg;

    // geometry limits and pixel format
    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int PIXEL_BITS    = 8;

    // derived widths
    localparam int COL_BITS      = $clog2(MAX_WIDTH);
    localparam int WCNT_BITS     = COL_BITS + 1;
    localparam int ROW_BITS      = $clog2(MAX_HEIGHT);
    localparam int HCNT_BITS     = ROW_BITS + 1;
    localparam int VROW_BITS     = HCNT_BITS + 1;

    // register field widths
    localparam int WID_BITS      = 11;
    localparam int HGT_BITS      = 13;
    localparam int MASK_BITS     = 9;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 13;

    // register reset values
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;
    localparam int MASK_RESET    = 511;

    typedef logic [PIXEL_BITS-1:0] t_pix;

    localparam t_pix PIXEL_MAX = '1;

    // register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_MASK   = 2'd2
    } t_cfg_idx;

    // item opcodes
    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    // one window step as decided by the scan logic
    typedef struct packed {
        logic                 push;
        logic [COL_BITS-1:0]  ci;
        t_pix                 pix;
        logic                 res_valid;
        logic [MASK_BITS-1:0] emask;
        logic                 last;
    } t_scan_item;

    // result item
    typedef struct packed {
        t_pix pixel_out;
        logic frame_last;
    } t_res;

    // zero reads as one, oversize reads as the maximum
    function automatic logic [WCNT_BITS-1:0] clamp_width(input logic [WID_BITS-1:0] v);
        if (v == '0) begin
            return WCNT_BITS'(1);
        end else if (int'(v) > MAX_WIDTH) begin
            return WCNT_BITS'(MAX_WIDTH);
        end else begin
            return WCNT_BITS'(v);
        end
    endfunction

    function automatic logic [HCNT_BITS-1:0] clamp_height(input logic [HGT_BITS-1:0] v);
        if (v == '0) begin
            return HCNT_BITS'(1);
        end else if (int'(v) > MAX_HEIGHT) begin
            return HCNT_BITS'(MAX_HEIGHT);
        end else begin
            return HCNT_BITS'(v);
        end
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/wbd_intf.sv -----
// wbd_intf: valid/ready channel interfaces for pixel items, results and config writes
// depends on wbd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface wbd_pix_if;
    import wbd_pkg::*;

    logic valid;
    logic ready;
    logic op;
    t_pix pixel_in;

    modport source (output valid, output op, output pixel_in, input ready);
    modport sink   (input valid, input op, input pixel_in, output ready);
endinterface

interface wbd_res_if;
    import wbd_pkg::*;

    logic valid;
    logic ready;
    t_pix pixel_out;
    logic frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

interface wbd_cfg_if;
    import wbd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/window_binary_dilate_3x3.sv -----
// window_binary_dilate_3x3: top level of the streaming 3x3 binary dilation block
// depends on wbd_pkg, wbd_intf, wbd_scan, wbd_core, wbd_obuf
//
//   port     dir   carries                          accepted when
//   i_pix    in    op, pixel_in                     i_pix.valid && i_pix.ready
//   o_res    out   pixel_out, frame_last            o_res.valid && o_res.ready
//   i_cfg    in    index, data (register write)     i_cfg.valid (ready tied high)
//
// One item per clock while the output buffer has space. An item is registered, its row
// store column read from the RAM, and the result lands in the output buffer.
// Results lag the pixel stream by one image row plus one pixel; width+1 drain items
// after the last pixel flush the final row. Synchronous active-low reset, no clearing
// pass: row stores are only read where the window lies inside the image.
// The output buffer holds two results; input stalls only when it is full.
`timescale 1ns / 1ps
`default_nettype none

module window_binary_dilate_3x3 (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    wbd_pix_if.sink   i_pix,
    wbd_res_if.source o_res,
    wbd_cfg_if.sink   i_cfg
);
    import wbd_pkg::*;

    logic       accept;
    logic       core_ready;
    logic       space;
    logic       push;
    t_scan_item item;
    t_res       res;

    assign i_pix.ready = core_ready;
    assign accept      = i_pix.valid && core_ready;

    // position decode and registers
    wbd_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .i_accept (accept),
        .i_op     (i_pix.op),
        .i_pixel  (i_pix.pixel_in),
        .o_item   (item)
    );

    // window and result
    wbd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (item),
        .o_ready  (core_ready),
        .i_space  (space),
        .o_push   (push),
        .o_res    (res)
    );

    // result buffer
    wbd_obuf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_res    (res),
        .o_space  (space),
        .o_res    (o_res)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/wbd_ram.sv -----
// wbd_ram: generic simple dual-port RAM, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module wbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/wbd_scan.sv -----
// wbd_scan: config registers, raster counters and window position decode
// depends on wbd_pkg and wbd_intf
`timescale 1ns / 1ps
`default_nettype none

module wbd_scan (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    wbd_cfg_if.sink                   i_cfg,
    input  wire logic                 i_accept,
    input  wire logic                 i_op,
    input  wire wbd_pkg::t_pix        i_pixel,
    output wbd_pkg::t_scan_item       o_item
);
    import wbd_pkg::*;

    logic [WCNT_BITS-1:0] r_width,  n_width;
    logic [HCNT_BITS-1:0] r_height, n_height;
    logic [MASK_BITS-1:0] r_mask,   n_mask;
    logic [COL_BITS-1:0]  r_col,    n_col;
    logic [ROW_BITS-1:0]  r_row,    n_row;
    logic [WCNT_BITS-1:0] r_drain,  n_drain;
    logic                 r_done,   n_done;

    logic                 is_pixel;
    logic                 drain_col;
    logic [VROW_BITS-1:0] vrow;
    logic [WCNT_BITS-1:0] vcol;
    logic [VROW_BITS-1:0] vsub;
    logic [VROW_BITS-1:0] crow;
    logic [WCNT_BITS-1:0] ccol;
    logic [2:0]           row_ok;
    logic [2:0]           col_ok;

    assign i_cfg.ready = 1'b1;

    // virtual position of this item; drain ticks walk one row past the frame
    always_comb begin
        is_pixel  = (t_op'(i_op) == OP_PIXEL);
        drain_col = (r_drain < r_width);
        if (is_pixel) begin
            vrow = VROW_BITS'(r_row);
            vcol = WCNT_BITS'(r_col);
        end else if (drain_col) begin
            vrow = VROW_BITS'(r_height);
            vcol = r_drain;
        end else begin
            vrow = VROW_BITS'(r_height) + VROW_BITS'(1);
            vcol = '0;
        end
    end

    // window center trails by one row and one pixel
    always_comb begin
        vsub = (vcol != '0) ? VROW_BITS'(1) : VROW_BITS'(2);
        crow = vrow - vsub;
        ccol = (vcol != '0) ? (vcol - WCNT_BITS'(1)) : (r_width - WCNT_BITS'(1));
        row_ok[0] = (crow != '0);
        row_ok[1] = 1'b1;
        row_ok[2] = (crow != VROW_BITS'(r_height) - VROW_BITS'(1));
        col_ok[0] = (ccol != '0);
        col_ok[1] = 1'b1;
        col_ok[2] = (ccol != r_width - WCNT_BITS'(1));

        o_item.push      = is_pixel || r_done;
        o_item.ci        = vcol[COL_BITS-1:0];
        o_item.pix       = is_pixel ? i_pixel : '0;
        o_item.res_valid = (vrow >= vsub) && (crow < VROW_BITS'(r_height));
        o_item.last      = !row_ok[2] && !col_ok[2];
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                o_item.emask[i*3+j] = r_mask[i*3+j] && row_ok[i] && col_ok[j];
            end
        end
    end

    // register writes and counter stepping
    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_mask   = r_mask;
        n_col    = r_col;
        n_row    = r_row;
        n_drain  = r_drain;
        n_done   = r_done;
        if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_WIDTH: begin
                    n_width = clamp_width(i_cfg.data[WID_BITS-1:0]);
                    n_col   = '0;
                    n_row   = '0;
                    n_drain = '0;
                    n_done  = 1'b0;
                end
                CFG_HEIGHT: begin
                    n_height = clamp_height(i_cfg.data[HGT_BITS-1:0]);
                    n_col    = '0;
                    n_row    = '0;
                    n_drain  = '0;
                    n_done   = 1'b0;
                end
                CFG_MASK: begin
                    n_mask = i_cfg.data[MASK_BITS-1:0];
                end
                default: begin
                end
            endcase
        end else if (i_accept) begin
            if (is_pixel) begin
                // a pixel during a pending tail starts the next frame
                if (r_done) begin
                    n_done  = 1'b0;
                    n_drain = '0;
                end
                if (WCNT_BITS'(r_col) + WCNT_BITS'(1) >= r_width) begin
                    n_col = '0;
                    if (HCNT_BITS'(r_row) + HCNT_BITS'(1) >= r_height) begin
                        n_row   = '0;
                        n_done  = 1'b1;
                        n_drain = '0;
                    end else begin
                        n_row = r_row + ROW_BITS'(1);
                    end
                end else begin
                    n_col = r_col + COL_BITS'(1);
                end
            end else if (r_done) begin
                if (r_drain >= r_width) begin
                    n_drain = '0;
                    n_done  = 1'b0;
                end else begin
                    n_drain = r_drain + WCNT_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WCNT_BITS'(WIDTH_RESET);
            r_height <= HCNT_BITS'(HEIGHT_RESET);
            r_mask   <= MASK_BITS'(MASK_RESET);
            r_col    <= '0;
            r_row    <= '0;
            r_drain  <= '0;
            r_done   <= 1'b0;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_mask   <= n_mask;
            r_col    <= n_col;
            r_row    <= n_row;
            r_drain  <= n_drain;
            r_done   <= n_done;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/wbd_core.sv -----
// wbd_core: row store access, 3x3 window registers and the dilation result
// depends on wbd_pkg and wbd_ram
`timescale 1ns / 1ps
`default_nettype none

module wbd_core (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire wbd_pkg::t_scan_item  i_item,
    output logic                      o_ready,
    input  wire logic                 i_space,
    output logic                      o_push,
    output wbd_pkg::t_res             o_res
);
    import wbd_pkg::*;

    logic                      r_s1_valid, n_s1_valid;
    t_scan_item                r_s1;
    logic                      r_byp;
    logic [2*PIXEL_BITS-1:0]   r_byp_data;
    t_pix                      r_win [3][3];

    logic                      fire;
    logic                      load;
    logic [2*PIXEL_BITS-1:0]   rd_data;
    logic [2*PIXEL_BITS-1:0]   wr_data;
    t_pix                      up_eff;
    t_pix                      mid_eff;
    t_pix                      win_n [3][3];
    logic                      hit;

    assign fire    = r_s1_valid && i_space;
    assign load    = i_accept && i_item.push;
    assign o_ready = !r_s1_valid || i_space;

    // upper row in the high half, middle row in the low half
    wbd_ram #(
        .WIDTH (2 * PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (fire),
        .i_waddr (r_s1.ci),
        .i_wdata (wr_data),
        .i_re    (load),
        .i_raddr (i_item.ci),
        .o_rdata (rd_data)
    );

    // column read in the cycle its own address was written takes the written pair
    always_comb begin
        up_eff  = r_byp ? r_byp_data[2*PIXEL_BITS-1:PIXEL_BITS] : rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
        mid_eff = r_byp ? r_byp_data[PIXEL_BITS-1:0] : rd_data[PIXEL_BITS-1:0];
        wr_data = {mid_eff, r_s1.pix};
    end

    // shifted window and masked neighbor test
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            win_n[i][0] = r_win[i][1];
            win_n[i][1] = r_win[i][2];
        end
        win_n[0][2] = up_eff;
        win_n[1][2] = mid_eff;
        win_n[2][2] = r_s1.pix;
        hit = 1'b0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (r_s1.emask[i*3+j] && (win_n[i][j] != '0)) begin
                    hit = 1'b1;
                end
            end
        end
        o_push           = fire && r_s1.res_valid;
        o_res.pixel_out  = hit ? PIXEL_MAX : win_n[1][1];
        o_res.frame_last = r_s1.last;
    end

    // stage occupancy
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (load) begin
            n_s1_valid = 1'b1;
        end else if (fire) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else begin
            r_s1_valid <= n_s1_valid;
            if (fire) begin
                r_win <= win_n;
            end
        end
    end

    // stage payload and bypass capture
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s1       <= i_item;
            r_byp      <= fire && (i_item.ci == r_s1.ci);
            r_byp_data <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/wbd_obuf.sv -----
// wbd_obuf: two-entry result buffer between the window stage and the result channel
// depends on wbd_pkg and wbd_intf
`timescale 1ns / 1ps
`default_nettype none

module wbd_obuf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire wbd_pkg::t_res    i_res,
    output logic                  o_space,
    wbd_res_if.source             o_res
);
    import wbd_pkg::*;

    t_res       r_buf [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count,  n_count;
    logic       pop;
    t_res       head;

    // space is judged on the registered count only
    assign o_space = (r_count != 2'd2);
    assign pop     = o_res.valid && o_res.ready;

    always_comb begin
        head             = r_buf[r_rd_ptr];
        o_res.valid      = (r_count != 2'd0);
        o_res.pixel_out  = head.pixel_out;
        o_res.frame_last = head.frame_last;
    end

    // pointer and count update
    always_comb begin
        n_wr_ptr = i_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_res;
        end
    end

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// testbench: self-checking bench for the streaming 3x3 binary dilation block
// depends on wbd_pkg, wbd_intf and the window_binary_dilate_3x3 rtl
// a directed table, mostly 1x1 frames, then random frames under three pacing schemes
`timescale 1ns / 1ps

module testbench;
    import wbd_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 150;
    localparam int RAND_ITEMS    = 400;
    localparam int EDGE_ITEMS    = 40;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PLAN_ROWS     = 29;

    // index with no register behind it
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

    // one row of the directed table: a register write or an item
    typedef struct {
        bit                       is_cfg;
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [CFG_DATA_BITS-1:0] data;
        t_op                      op;
        t_pix                     pix;
        bit                       typed;
        t_pix                     want_pix;
        logic                     want_last;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    wbd_pix_if pix_bus ();
    wbd_res_if res_bus ();
    wbd_cfg_if cfg_bus ();

    window_binary_dilate_3x3 dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // shadow of the block: row lines, 3x3 window, scan position, registers
    t_pix                 line_top [MAX_WIDTH] = '{default: '0};
    t_pix                 line_mid [MAX_WIDTH] = '{default: '0};
    t_pix                 win [3][3] = '{default: '0};
    int                   col_pos = 0;
    int                   row_pos = 0;
    int                   flush_pos = 0;
    bit                   tail_pending = 1'b0;
    int                   cur_w = WIDTH_RESET;
    int                   cur_h = HEIGHT_RESET;
    logic [MASK_BITS-1:0] cur_mask = MASK_RESET;

    t_res dilated_q [$];
    int   err_count = 0;
    int   live_items = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_reqs = 0;
    int   cycle_count = 0;

    // directed table: reset geometry first, then 1x1 frames whose result is obvious
    t_row plan [PLAN_ROWS] = '{
        // 640x480 after reset: too early for any result, stray drain ignored
        '{1'b0, CFG_SPARE,  13'd0,    OP_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
        '{1'b0, CFG_SPARE,  13'd0,    OP_PIXEL, 8'd255, 1'b0, 8'd0,   1'b0},
        '{1'b0, CFG_SPARE,  13'd0,    OP_DRAIN, 8'd255, 1'b0, 8'd0,   1'b0},
        '{1'b0, CFG_SPARE,  13'd0,    OP_PIXEL, 8'd1,   1'b0, 8'd0,   1'b0},
        // unused index, zero geometry reads as 1x1, mask with upper data bits set
        '{1'b1, CFG_SPARE,  13'h1FFF, OP_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
        '{1'b1, CFG_WIDTH,  13'd0,    OP_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
        '{1'b1, CFG_HEIGHT, 13'd0,    OP_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
        '{1'b1, CFG_MASK,   13'h1FFF, OP_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
        // full mask: nonzero center dilates, extra drain ignored
        '{1'b0, CFG_SPARE,  13'd0,    OP_PIXEL, 8'd200, 1'b0, 8'd0,   1'b0},
        '{1'b0, CFG_SPARE,  13'd0,    OP_DRAIN, 8'd0,   1'b0, 8'd0,   1'b0},
        '{1'b0, CFG_SPARE,  13'd0,    OP_DRAIN, 8'd17,  1'b1, 8'd255, 1'b1},
        '{1'b0, CFG_SPARE,  13'd0,    OP_DRAIN, 8'd0,   1'b0, 8'd0,   1'b0},
        // empty mask copies the center
        '{1'b1, CFG_MASK,   13'd0,    OP_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
        '{1'b0, CFG_SPARE,  13'd0,    OP_PIXEL, 8'd77,  1'b0, 8'd0,   1'b0},
        '{1'b0, CFG_SPARE,  13'd0,    OP_DRAIN, 8'd0,   1'b0, 8'd0,   1'b0},
        '{1'b0, CFG_SPARE,  13'd0,    OP_DRAIN, 8'd0,   1'b1, 8'd77,  1'b1},
        // center only
        '{1'b1, CFG_MASK,   13'h010,  OP_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
        '{1'b0, CFG_SPARE,  13'd0,    OP_PIXEL, 8'd1,   1'b0, 8'd0,   1'b0},
        '{1'b0, CFG_SPARE,  13'd0,    OP_DRAIN, 8'd0,   1'b0, 8'd0,   1'b0},
        '{1'b0, CFG_SPARE,  13'd0,    OP_DRAIN, 8'd0,   1'b1, 8'd255, 1'b1},
        // all but center: every neighbor is off the image
        '{1'b1, CFG_MASK,   13'h1EF,  OP_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
        '{1'b0, CFG_SPARE,  13'd0,    OP_PIXEL, 8'd128, 1'b0, 8'd0,   1'b0},
        '{1'b0, CFG_SPARE,  13'd0,    OP_DRAIN, 8'd0,   1'b0, 8'd0,   1'b0},
        '{1'b0, CFG_SPARE,  13'd0,    OP_DRAIN, 8'd0,   1'b1, 8'd128, 1'b1},
        // next frame starts while the tail is still pending
        '{1'b0, CFG_SPARE,  13'd0,    OP_PIXEL, 8'd200, 1'b0, 8'd0,   1'b0},
        '{1'b0, CFG_SPARE,  13'd0,    OP_DRAIN, 8'd0,   1'b0, 8'd0,   1'b0},
        '{1'b0, CFG_SPARE,  13'd0,    OP_PIXEL, 8'd9,   1'b0, 8'd0,   1'b0},
        '{1'b0, CFG_SPARE,  13'd0,    OP_DRAIN, 8'd0,   1'b0, 8'd0,   1'b0},
        '{1'b0, CFG_SPARE,  13'd0,    OP_DRAIN, 8'd0,   1'b0, 8'd0,   1'b0}
    };

    function automatic int fit_dim(input int v, input int top);
        if (v == 0) begin
            return 1;
        end
        return (v > top) ? top : v;
    endfunction

    function automatic void restart_scan();
        col_pos = 0;
        row_pos = 0;
        flush_pos = 0;
        tail_pending = 1'b0;
    endfunction

    // shift one pixel into lines and window at scan position (r, c)
    function automatic bit shift_window(input int r, input int c, input t_pix pix,
                                        output t_res res);
        int   ci;
        int   cr;
        int   cc;
        int   nr;
        int   nc;
        t_pix up;
        t_pix mid;
        bit   hit;
        ci  = (c < MAX_WIDTH) ? c : 0;
        up  = line_top[ci];
        mid = line_mid[ci];
        line_top[ci] = mid;
        line_mid[ci] = pix;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = up;
        win[1][2] = mid;
        win[2][2] = pix;
        res = '0;
        // center sits one pixel behind, wrapping to the previous row at column 0
        if (c >= 1) begin
            cr = r - 1;
            cc = c - 1;
        end else begin
            cr = r - 2;
            cc = cur_w - 1;
        end
        if (cr < 0 || cr >= cur_h) begin
            return 1'b0;
        end
        hit = 1'b0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                nr = cr + i - 1;
                nc = cc + j - 1;
                if (cur_mask[i * 3 + j] && nr >= 0 && nr < cur_h && nc >= 0 && nc < cur_w
                        && win[i][j] != '0) begin
                    hit = 1'b1;
                end
            end
        end
        res.pixel_out  = hit ? PIXEL_MAX : win[1][1];
        res.frame_last = (cr == cur_h - 1) && (cc == cur_w - 1);
        return 1'b1;
    endfunction

    // advance the shadow by one accepted item
    function automatic bit dilate_step(input t_op op, input t_pix pix, output t_res res);
        bit made;
        res = '0;
        if (op == OP_PIXEL) begin
            if (tail_pending) begin
                tail_pending = 1'b0;
                flush_pos = 0;
            end
            made = shift_window(row_pos, col_pos, pix, res);
            col_pos++;
            if (col_pos >= cur_w) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= cur_h) begin
                    row_pos = 0;
                    tail_pending = 1'b1;
                    flush_pos = 0;
                end
            end
            return made;
        end
        if (!tail_pending) begin
            return 1'b0;
        end
        if (flush_pos < cur_w) begin
            made = shift_window(cur_h, flush_pos, '0, res);
        end else begin
            made = shift_window(cur_h + 1, 0, '0, res);
        end
        flush_pos++;
        if (flush_pos > cur_w) begin
            flush_pos = 0;
            tail_pending = 1'b0;
        end
        return made;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                      input logic [CFG_DATA_BITS-1:0] val);
        case (idx)
            CFG_WIDTH: begin
                cur_w = fit_dim(int'(val[WID_BITS-1:0]), MAX_WIDTH);
                restart_scan();
            end
            CFG_HEIGHT: begin
                cur_h = fit_dim(int'(val[HGT_BITS-1:0]), MAX_HEIGHT);
                restart_scan();
            end
            CFG_MASK: begin
                cur_mask = val[MASK_BITS-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    function automatic t_pix rand_pix();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return '0;
        end
        if (roll < 70) begin
            return PIXEL_MAX;
        end
        return t_pix'($urandom_range(1, 254));
    endfunction

    // stop offering items until every expected result is back, then let the pipe empty
    task automatic settle();
        pix_bus.valid <= 1'b0;
        while (dilated_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        bit took;
        settle();
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do begin
            @(negedge i_clk);
            took = cfg_bus.ready;
            @(posedge i_clk);
        end while (!took);
        apply_reg(idx, val);
        cfg_bus.valid <= 1'b0;
    endtask

    // offer one item, wait for it to be taken, then record what it should produce
    task automatic put_item(input t_op op, input t_pix pix, input bit typed,
                            input t_pix want_pix, input logic want_last);
        bit   took;
        bit   made;
        t_res res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            pix_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_bus.valid    <= 1'b1;
        pix_bus.op       <= op;
        pix_bus.pixel_in <= pix;
        do begin
            @(negedge i_clk);
            took = pix_bus.ready;
            @(posedge i_clk);
        end while (!took);
        if (op == OP_PIXEL || tail_pending) begin
            live_items++;
        end
        made = dilate_step(op, pix, res);
        if (typed) begin
            res.pixel_out  = want_pix;
            res.frame_last = want_last;
            made = 1'b1;
        end
        if (made) begin
            dilated_q = {dilated_q, res};
        end
    endtask

    // one frame at the current geometry, well formed or broken depending on style
    task automatic send_frame(input int style);
        int npix;
        int ntail;
        npix  = cur_w * cur_h;
        ntail = cur_w + 1;
        if (style == 9) begin
            // noise: random ops in random places
            repeat ($urandom_range(1, 6)) begin
                put_item(t_op'($urandom_range(0, 1)), t_pix'($urandom), 1'b0, '0, 1'b0);
            end
        end else begin
            if (style == 8) begin
                npix = $urandom_range(1, npix);
            end
            if (style == 7) begin
                ntail = $urandom_range(0, cur_w);
            end
            for (int k = 0; k < npix; k++) begin
                if ($urandom_range(0, 19) == 0) begin
                    put_item(OP_DRAIN, t_pix'($urandom), 1'b0, '0, 1'b0);
                end
                put_item(OP_PIXEL, rand_pix(), 1'b0, '0, 1'b0);
            end
            if (style != 8) begin
                repeat (ntail) put_item(OP_DRAIN, t_pix'($urandom), 1'b0, '0, 1'b0);
            end
            if (style < 7 && $urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 2)) begin
                    put_item(OP_DRAIN, t_pix'($urandom), 1'b0, '0, 1'b0);
                end
            end
        end
    endtask

    // result side pacing, with long hold-offs counted here on request
    initial begin : res_pace
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        res_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // compare each accepted result with the oldest expected one
    always @(negedge i_clk) begin : res_check
        t_res want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (dilated_q.size() == 0) begin
                $error("result with none expected: pixel_out %0d frame_last %0d",
                       res_bus.pixel_out, res_bus.frame_last);
                err_count++;
            end else begin
                want = dilated_q.pop_front();
                if (res_bus.pixel_out !== want.pixel_out) begin
                    $error("pixel_out: expected %0d, got %0d", want.pixel_out,
                           res_bus.pixel_out);
                    err_count++;
                end
                if (res_bus.frame_last !== want.frame_last) begin
                    $error("frame_last: expected %0d, got %0d", want.frame_last,
                           res_bus.frame_last);
                    err_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("window_binary_dilate_3x3: mismatch");
            $finish;
        end
    end

    // stimulus
    initial begin : stim
        int                       phase;
        int                       roll;
        int                       w;
        int                       h;
        logic [CFG_DATA_BITS-1:0] val;
        phase = 0;
        pix_bus.valid    = 1'b0;
        pix_bus.op       = OP_PIXEL;
        pix_bus.pixel_in = '0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = CFG_WIDTH;
        cfg_bus.data     = '0;
        i_rst_n          = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        send_idle_pct = 34;
        recv_idle_pct = 84;
        for (int r = 0; r < PLAN_ROWS; r++) begin
            if (plan[r].is_cfg) begin
                write_reg(plan[r].idx, plan[r].data);
            end else begin
                put_item(plan[r].op, plan[r].pix, plan[r].typed, plan[r].want_pix,
                         plan[r].want_last);
            end
        end

        // random settings, each followed by a few frames
        live_items = 0;
        while (live_items < RAND_ITEMS) begin
            phase++;
            if (live_items < RAND_ITEMS / 3) begin
                send_idle_pct = 34;
                recv_idle_pct = 84;
            end else if (live_items < 2 * RAND_ITEMS / 3) begin
                send_idle_pct = 84;
                recv_idle_pct = 34;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            roll = $urandom_range(0, 9);
            if (phase == 3 || phase == 12) begin
                // big enough frame to back up behind a long hold-off
                w = 8;
                h = 4;
                roll = 2;
            end else begin
                w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                h = $urandom_range(1, 5);
            end
            if (roll != 0) begin
                val = {2'($urandom_range(0, 3)), 11'(w)};
                write_reg(CFG_WIDTH, val);
                write_reg(CFG_HEIGHT, 13'(h));
            end
            if (roll == 1) begin
                write_reg(CFG_SPARE, 13'($urandom));
            end
            case ($urandom_range(0, 5))
                0:       val = 13'd0;
                1:       val = 13'd511;
                default: val = 13'($urandom);
            endcase
            write_reg(CFG_MASK, val);
            if (phase == 3 || phase == 12) begin
                hold_reqs <= hold_reqs + 1;
                send_frame(0);
            end else begin
                repeat ($urandom_range(1, 3)) send_frame($urandom_range(0, 9));
            end
        end

        // start of the widest single-row frame, then of the tallest single-column frame
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_WIDTH, 13'h1FFF);
        write_reg(CFG_HEIGHT, 13'd1);
        write_reg(CFG_MASK, 13'd511);
        repeat (EDGE_ITEMS) put_item(OP_PIXEL, rand_pix(), 1'b0, '0, 1'b0);
        write_reg(CFG_WIDTH, 13'd1);
        write_reg(CFG_HEIGHT, 13'h1FFF);
        write_reg(CFG_MASK, 13'd0);
        repeat (EDGE_ITEMS) put_item(OP_PIXEL, rand_pix(), 1'b0, '0, 1'b0);

        settle();
        repeat (16) @(posedge i_clk);
        if (err_count == 0) begin
            $display("window_binary_dilate_3x3: match");
        end else begin
            $display("window_binary_dilate_3x3: mismatch");
        end
        $finish;
    end

endmodule
